@@ hdl/dchb_pkg.sv @@
// shared constants and the driver word builder for the h-bridge command decoder
// no dependencies
package dchb_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned TDATA_W  = 24;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned BITS_N   = 9;
    localparam int unsigned IDX_W    = 2;

    localparam logic [POS_W-1:0] POS_BYTE0    = 3'd0;
    localparam logic [POS_W-1:0] POS_BYTE1    = 3'd1;
    localparam logic [POS_W-1:0] POS_BYTE2    = 3'd2;
    localparam logic [POS_W-1:0] POS_BYTE3    = 3'd3;
    localparam logic [POS_W-1:0] POS_SAT      = 3'd4;
    localparam logic [POS_W-1:0] POS_UNSYNCED = 3'd7;

    localparam logic [IDX_W-1:0] IDX_LAST_WORD = 2'd2;

    localparam logic KIND_WORD = 1'b0;
    localparam logic KIND_FWD  = 1'b1;

    localparam logic [BYTE_W-1:0] MARK_BIT = 8'h80;

    // one chip: doubled enables and a one-hot polarity pair per bridge
    function automatic logic [WORD_W-1:0] chip_word(input logic [2:0] e,
                                                    input logic [2:0] d);
        logic [5:0] en6;
        logic [5:0] cc6;
        en6 = {e[2], e[2], e[1], e[1], e[0], e[0]};
        cc6 = {~d[2], d[2], ~d[1], d[1], ~d[0], d[0]};
        return {3'b000, en6[5:1], en6[0], cc6, 1'b0};
    endfunction

endpackage

@@ hdl/daisy_chain_hbridge_cmd_decoder_core.sv @@
// top level of the daisy-chained h-bridge command decoder: input register,
// frame decode and result register; depends on dchb_pkg
//
// results of an accepted byte move from the input register to the result register
// when it is free; throughput: 1 byte per cycle while it is free; frame byte 2 holds
// the input register while its three driver words pass the single result register
// reset: synchronous active-low, clears handshake state, enables and directions,
// and leaves the decoder unsynced until the first marked byte
module daisy_chain_hbridge_cmd_decoder_core
    import dchb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [BYTE_W-1:0]  i_s_axis_tdata,   // rx_byte
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata,   // driver_word [15:0], fwd_byte [23:16]
    output logic               o_m_axis_tuser,   // kind
    output logic               o_m_axis_tlast    // last
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic [POS_W-1:0]  r_pos;
    logic [BITS_N-1:0] r_en;
    logic [BITS_N-1:0] r_dir;
    logic [IDX_W-1:0]  r_idx;

    logic               r_out_valid;
    logic [TDATA_W-1:0] r_out_data;
    logic               r_out_kind;
    logic               r_out_last;

    logic [POS_W-1:0]   pos_eff;
    logic [POS_W-1:0]   n_pos;
    logic [BITS_N-1:0]  n_en;
    logic [BITS_N-1:0]  n_dir;
    logic [2:0]         lo;
    logic [2:0]         hi;
    logic               has_out;
    logic               out_free;
    logic               emit;
    logic               last_res;
    logic               finish;
    logic [2:0]         sel_e;
    logic [2:0]         sel_d;
    logic [TDATA_W-1:0] res_data;
    logic               res_kind;

    assign lo       = r_in_byte[2:0];
    assign hi       = r_in_byte[5:3];
    assign pos_eff  = r_in_byte[7] ? POS_BYTE0 : r_pos;
    assign out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_en     = r_en;
        n_dir    = r_dir;
        n_pos    = POS_UNSYNCED;
        has_out  = 1'b0;
        last_res = 1'b1;
        res_kind = KIND_FWD;
        res_data = '0;
        sel_e    = r_en[2:0];
        sel_d    = r_dir[2:0];
        unique case (r_idx)
            2'd0: begin
                sel_e = r_en[8:6];
                sel_d = hi;
            end
            2'd1: begin
                sel_e = r_en[5:3];
                sel_d = lo;
            end
            default: begin
                sel_e = r_en[2:0];
                sel_d = r_dir[2:0];
            end
        endcase
        case (pos_eff)
            POS_BYTE0: begin
                n_en  = {r_en[8:6], hi, lo};
                n_pos = POS_BYTE1;
            end
            POS_BYTE1: begin
                n_en  = {lo, r_en[5:0]};
                n_dir = {r_dir[8:3], hi};
                n_pos = POS_BYTE2;
            end
            POS_BYTE2: begin
                n_dir    = {hi, lo, r_dir[2:0]};
                n_pos    = POS_BYTE3;
                has_out  = 1'b1;
                last_res = (r_idx == IDX_LAST_WORD);
                res_kind = KIND_WORD;
                res_data = {{(TDATA_W-WORD_W){1'b0}}, chip_word(sel_e, sel_d)};
            end
            POS_BYTE3: begin
                n_pos    = POS_SAT;
                has_out  = 1'b1;
                res_data = {r_in_byte | MARK_BIT, {WORD_W{1'b0}}};
            end
            POS_SAT: begin
                n_pos    = POS_SAT;
                has_out  = 1'b1;
                res_data = {r_in_byte, {WORD_W{1'b0}}};
            end
            default: begin
                n_pos = POS_UNSYNCED;
            end
        endcase
    end

    assign emit   = r_in_valid && has_out && out_free;
    assign finish = r_in_valid && (!has_out || (emit && last_res));
    assign o_s_axis_tready = !r_in_valid || finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pos      <= POS_UNSYNCED;
            r_en       <= '0;
            r_dir      <= '0;
            r_idx      <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (finish) begin
                r_pos <= n_pos;
                r_en  <= n_en;
                r_dir <= n_dir;
                r_idx <= '0;
            end else if (emit) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= res_data;
            r_out_kind <= res_kind;
            r_out_last <= last_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

endmodule

@@ tb/sv/dchb_result_checker.sv @@
// result checker for the h-bridge command decoder: decodes every accepted input item,
// keeps the expected results in order and compares each accepted output item
// depends on dchb_pkg
module dchb_result_checker
    import dchb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [BYTE_W-1:0]  i_s_tdata,    // rx_byte
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    input  logic [TDATA_W-1:0] i_m_tdata,    // driver_word [15:0], fwd_byte [23:16]
    input  logic               i_m_tuser,    // kind
    input  logic               i_m_tlast,    // last
    output int                 o_fail_cnt,
    output int                 o_pending_cnt
);

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] word;
        logic [BYTE_W-1:0] fwd;
        logic              last;
    } t_cmd_result;

    t_cmd_result      expected_q[$];
    t_cmd_result      got;
    t_cmd_result      want;
    logic [POS_W-1:0] frame_pos;
    logic [BITS_N-1:0] enables;
    logic [BITS_N-1:0] directions;

    function automatic logic [WORD_W-1:0] bridge_word(input logic [2:0] e,
                                                      input logic [2:0] d);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int j = 0; j < 3; j++) begin
            if (e[j]) begin
                w[7 + 2*j] = 1'b1;
                w[8 + 2*j] = 1'b1;
            end
            if (d[j]) begin
                w[1 + 2*j] = 1'b1;
            end else begin
                w[2 + 2*j] = 1'b1;
            end
        end
        return w;
    endfunction

    function automatic t_cmd_result word_item(input int chip, input logic last);
        t_cmd_result r;
        r.kind = KIND_WORD;
        r.word = bridge_word(enables[3*chip +: 3], directions[3*chip +: 3]);
        r.fwd  = '0;
        r.last = last;
        return r;
    endfunction

    function automatic t_cmd_result fwd_item(input logic [BYTE_W-1:0] b);
        t_cmd_result r;
        r.kind = KIND_FWD;
        r.word = '0;
        r.fwd  = b;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        if (b[7]) begin
            frame_pos = POS_BYTE0;
        end
        case (frame_pos)
            POS_BYTE0: begin
                enables[5:0] = b[5:0];
            end
            POS_BYTE1: begin
                enables[8:6]    = b[2:0];
                directions[2:0] = b[5:3];
            end
            POS_BYTE2: begin
                directions[8:3] = b[5:0];
                // last chip of the chain goes out first
                expected_q.push_back(word_item(2, 1'b0));
                expected_q.push_back(word_item(1, 1'b0));
                expected_q.push_back(word_item(0, 1'b1));
            end
            POS_BYTE3: begin
                expected_q.push_back(fwd_item(b | MARK_BIT));
            end
            POS_SAT: begin
                expected_q.push_back(fwd_item(b));
            end
            default: begin
                frame_pos = POS_UNSYNCED;
            end
        endcase
        if (frame_pos < POS_SAT) begin
            frame_pos = frame_pos + 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_q.delete();
            frame_pos  = POS_UNSYNCED;
            enables    = '0;
            directions = '0;
            o_fail_cnt = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                decode_byte(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.kind = i_m_tuser;
                got.word = i_m_tdata[WORD_W-1:0];
                got.fwd  = i_m_tdata[WORD_W +: BYTE_W];
                got.last = i_m_tlast;
                if (expected_q.size() == 0) begin
                    if (o_fail_cnt < 10) begin
                        $display("unexpected item: kind %0d word %h fwd %h last %0d",
                                 got.kind, got.word, got.fwd, got.last);
                    end
                    o_fail_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.kind !== want.kind || got.word !== want.word ||
                        got.fwd !== want.fwd || got.last !== want.last) begin
                        if (o_fail_cnt < 10) begin
                            $display("mismatch: kind %0d/%0d word %h/%h fwd %h/%h last %0d/%0d",
                                     want.kind, got.kind, want.word, got.word,
                                     want.fwd, got.fwd, want.last, got.last);
                        end
                        o_fail_cnt++;
                    end
                end
            end
        end
        o_pending_cnt = expected_q.size();
    end

endmodule

@@ tb/sv/tb_daisy_chain_hbridge_cmd_decoder_core.sv @@
// testbench top for the h-bridge command decoder: clock, reset, byte stimulus with
// random idling on both streams, and the verdict; depends on dchb_pkg,
// dchb_result_checker and daisy_chain_hbridge_cmd_decoder_core
module tb_daisy_chain_hbridge_cmd_decoder_core;
    import dchb_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_ITEMS   = 60;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_valid;
    logic               s_ready;
    logic [BYTE_W-1:0]  s_data;
    logic               m_valid;
    logic               m_ready;
    logic [TDATA_W-1:0] m_data;
    logic               m_user;
    logic               m_last;
    int                 fail_cnt;
    int                 pending_cnt;
    int                 items_sent;
    int                 stall_left;
    logic               idle_on;

    daisy_chain_hbridge_cmd_decoder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    dchb_result_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_valid),
        .i_s_tready    (s_ready),
        .i_s_tdata     (s_data),
        .i_m_tvalid    (m_valid),
        .i_m_tready    (m_ready),
        .i_m_tdata     (m_data),
        .i_m_tuser     (m_user),
        .i_m_tlast     (m_last),
        .o_fail_cnt    (fail_cnt),
        .o_pending_cnt (pending_cnt)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_item(input logic [BYTE_W-1:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            s_data  <= 8'($urandom_range(0, 255));
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge i_clk); while (!s_ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        int choice;
        int extra;
        s_valid    = 1'b0;
        s_data     = '0;
        i_rst_n    = 1'b0;
        idle_on    = 1'b1;
        items_sent = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // unsynced bytes are dropped
        send_item(8'h00);
        send_item(8'h7F);
        send_item(8'h45);
        // all bridges off, then byte 3 and saturated forwarding
        send_item(8'h80);
        send_item(8'h00);
        send_item(8'h00);
        send_item(8'h00);
        send_item(8'h7F);
        send_item(8'h7F);
        // all bridges on, all directions set
        send_item(8'hFF);
        send_item(8'h7F);
        send_item(8'h7F);
        send_item(8'h41);
        // mark mid-frame where byte 2 would be
        send_item(8'hAA);
        send_item(8'h15);
        send_item(8'h95);
        send_item(8'h2A);
        send_item(8'h6D);
        send_item(8'h33);
        // mark where byte 3 would be
        send_item(8'hC0);
        send_item(8'h07);
        send_item(8'h38);
        send_item(8'h81);
        send_item(8'h12);
        send_item(8'h24);
        send_item(8'h7F);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            idle_on = (items_sent < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
            choice  = $urandom_range(0, 9);
            if (choice == 0) begin
                extra = $urandom_range(1, 3);
                repeat (extra) send_item(8'($urandom_range(0, 255)));
            end else begin
                send_item({1'b1, 7'($urandom_range(0, 127))});
                send_item({1'b0, 7'($urandom_range(0, 127))});
                if (choice != 1) begin
                    send_item({1'b0, 7'($urandom_range(0, 127))});
                    extra = $urandom_range(0, 6);
                    repeat (extra) send_item({1'b0, 7'($urandom_range(0, 127))});
                end
            end
        end
        s_valid <= 1'b0;
        idle_on = 1'b0;

        wait (pending_cnt == 0);
        repeat (10) @(posedge i_clk);
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("tb_daisy_chain_hbridge_cmd_decoder_core OK");
        end else begin
            $display("tb_daisy_chain_hbridge_cmd_decoder_core NOT OK");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_daisy_chain_hbridge_cmd_decoder_core NOT OK");
        $finish;
    end

endmodule
